// ----- sv/md_pkg.sv -----
package md_pkg;

  localparam int POW_TABLE_BITS = 8;
  localparam int TAB_SIZE = (1 << POW_TABLE_BITS) + 1;
  localparam int LOG_R_BITS = 31 - POW_TABLE_BITS;
  localparam int EXP_R_BITS = 16 - POW_TABLE_BITS;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT_K = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT_RECIP = 2'd1;

  typedef logic [16:0] log_tab_t [TAB_SIZE];
  typedef logic [32:0] exp_tab_t [TAB_SIZE];

  typedef struct packed {
    logic [32:0] d;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [15:0] k;
    logic [16:0] recip;
  } cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    v = v_in;
    res = '0;
    bw = 64'h4000_0000_0000_0000;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= res + bw) begin
        v = v - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    logic [63:0] m;
    logic [16:0] f;
    for (int i = 0; i < (1 << POW_TABLE_BITS); i++) begin
      m = (64'd1 << 31) + (64'(i) << (31 - POW_TABLE_BITS));
      f = '0;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          f = f | (17'd1 << b);
          m = m >> 1;
        end
      end
      t[i] = f;
    end
    t[1 << POW_TABLE_BITS] = 17'd65536;
    return t;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    logic [63:0] root [POW_TABLE_BITS+1];
    logic [63:0] v;
    root[0] = 64'd1 << 32;
    for (int n = 1; n <= POW_TABLE_BITS; n++) root[n] = isqrt64(root[n-1] << 31);
    for (int i = 0; i < (1 << POW_TABLE_BITS); i++) begin
      v = 64'd1 << 31;
      for (int n = 0; n < POW_TABLE_BITS; n++) begin
        if (((i >> n) & 1) != 0) v = (v * root[POW_TABLE_BITS-n]) >> 31;
      end
      t[i] = v[32:0];
    end
    t[1 << POW_TABLE_BITS] = 33'h1_0000_0000;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- sv/md_front.sv -----
module md_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   in_elem_a,
  input  logic signed [31:0]   in_elem_b,
  input  logic                 in_last_pair,
  output logic                 q_valid,
  output md_pkg::item_t        q_item,
  input  logic                 q_pop
);

  md_pkg::item_t                   mem_r [md_pkg::QDEPTH];
  logic [md_pkg::QPTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [md_pkg::QPTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [md_pkg::QPTR_BITS:0]      cnt_r, cnt_nxt;
  logic signed [32:0]              diff;
  logic                            do_push, do_pop;
  md_pkg::item_t                   new_item;

  assign diff = {in_elem_a[31], in_elem_a} - {in_elem_b[31], in_elem_b};
  assign new_item.d = diff[32] ? 33'(-diff) : 33'(diff);
  assign new_item.last = in_last_pair;

  assign full = (cnt_r == (md_pkg::QPTR_BITS+1)'(md_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= new_item;
  end

endmodule

// ----- sv/md_power.sv -----
module md_power (
  input  logic          clk,
  input  logic          rst_n,
  input  md_pkg::cfg_t  cfg,
  input  logic          q_valid,
  input  md_pkg::item_t q_item,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   out_distance,
  output logic          out_saturated
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIN   = 7'b0000010,
    S_NORM  = 7'b0000100,
    S_LOG   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_EXP   = 7'b0100000,
    S_SCALE = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                root_r, root_nxt;
  logic                last_r, last_nxt;
  logic [63:0]         x_r, x_nxt;
  logic [5:0]          p_r, p_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [16:0]         lm_r, lm_nxt;
  logic signed [31:0]  e_r, e_nxt;
  logic signed [16:0]  n_r, n_nxt;
  logic [32:0]         mant_r, mant_nxt;
  logic [63:0]         sum_r, sum_nxt;
  logic                ovf_r, ovf_nxt;
  logic                ov_r, ov_nxt;
  logic [31:0]         dist_r, dist_nxt;
  logic                dsat_r, dsat_nxt;

  logic [6:0]          amt;
  logic [63:0]         top_bits;
  logic [md_pkg::POW_TABLE_BITS-1:0] li;
  logic [md_pkg::LOG_R_BITS-1:0]     lr;
  logic [16:0]         ldiff;
  logic [39:0]         lprod;
  logic signed [7:0]   pf;
  logic signed [23:0]  lval;
  logic signed [17:0]  coef;
  logic signed [41:0]  eprod;
  logic signed [41:0]  eshift;
  logic signed [32:0]  ee;
  logic [md_pkg::POW_TABLE_BITS-1:0] ei;
  logic [md_pkg::EXP_R_BITS-1:0]     er;
  logic [32:0]         ediff;
  logic [40:0]         eprod2;
  logic signed [17:0]  sh;
  logic [96:0]         wide;
  logic [63:0]         v;
  logic                vsat;
  logic [64:0]         acc;
  logic                out_free;

  assign empty = !ov_r;
  assign out_distance = dist_r;
  assign out_saturated = dsat_r;
  assign out_free = !ov_r || pop;
  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Binary search for the leading one: halving shift amounts, one per cycle.
  assign amt = 7'd32 >> step_r;
  assign top_bits = x_r >> (7'd64 - amt);

  assign li = x_r[62 -: md_pkg::POW_TABLE_BITS];
  assign lr = x_r[62-md_pkg::POW_TABLE_BITS -: md_pkg::LOG_R_BITS];
  assign ldiff = md_pkg::LOG_TAB[{1'b0, li} + 1'b1] - md_pkg::LOG_TAB[li];
  assign lprod = 40'(ldiff) * 40'(lr);

  assign pf = $signed({2'b00, p_r}) - (root_r ? 8'sd32 : 8'sd16);
  assign lval = $signed({pf, 16'h0000}) + $signed({7'b0, lm_r});
  assign coef = root_r ? $signed({1'b0, cfg.recip}) : $signed({2'b00, cfg.k});
  assign eprod = 42'(lval) * 42'(coef);
  assign eshift = root_r ? (eprod >>> 16) : (eprod >>> 12);

  assign ee = $signed({e_r[31], e_r}) + (root_r ? 33'sh10_0000 : 33'sh20_0000);
  assign ei = ee[15 -: md_pkg::POW_TABLE_BITS];
  assign er = ee[md_pkg::EXP_R_BITS-1:0];
  assign ediff = md_pkg::EXP_TAB[{1'b0, ei} + 1'b1] - md_pkg::EXP_TAB[ei];
  assign eprod2 = 41'(ediff) * 41'(er);

  always_comb begin
    vsat = 1'b0;
    v = '0;
    wide = '0;
    if (n_r > 17'sd31) begin
      sh = 18'(n_r) - 18'sd31;
      wide = {64'b0, mant_r} << sh[5:0];
      if (sh >= 18'sd64 || wide[96:64] != '0) vsat = 1'b1;
      else v = wide[63:0];
    end else begin
      sh = 18'sd31 - 18'(n_r);
      v = (sh >= 18'sd64) ? 64'd0 : (64'(mant_r) >> sh[5:0]);
    end
    if (root_r && v[63:32] != '0) vsat = 1'b1;
    if (vsat) v = root_r ? 64'h0000_0000_FFFF_FFFF : '1;
  end

  assign acc = {1'b0, sum_r} + {1'b0, v};

  always_comb begin
    state_nxt = state_r;
    root_nxt = root_r;
    last_nxt = last_r;
    x_nxt = x_r;
    p_nxt = p_r;
    step_nxt = step_r;
    lm_nxt = lm_r;
    e_nxt = e_r;
    n_nxt = n_r;
    mant_nxt = mant_r;
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    ov_nxt = ov_r;
    dist_nxt = dist_r;
    dsat_nxt = dsat_r;
    if (pop && ov_r) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          last_nxt = q_item.last;
          if (q_item.d != '0) begin
            x_nxt = {31'b0, q_item.d};
            root_nxt = 1'b0;
            p_nxt = 6'd63;
            step_nxt = '0;
            state_nxt = S_NORM;
          end else if (q_item.last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (sum_r == '0) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            dist_nxt = '0;
            dsat_nxt = ovf_r;
            ovf_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          x_nxt = sum_r;
          root_nxt = 1'b1;
          p_nxt = 6'd63;
          step_nxt = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (top_bits == '0) begin
          x_nxt = x_r << amt;
          p_nxt = p_r - amt[5:0];
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd5) state_nxt = S_LOG;
      end
      S_LOG: begin
        lm_nxt = md_pkg::LOG_TAB[li] + lprod[md_pkg::LOG_R_BITS +: 17];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        e_nxt = eshift[31:0];
        state_nxt = S_EXP;
      end
      S_EXP: begin
        n_nxt = ee[32:16];
        mant_nxt = md_pkg::EXP_TAB[ei] + eprod2[md_pkg::EXP_R_BITS +: 33];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (!root_r) begin
          if (acc[64]) begin
            sum_nxt = '1;
            ovf_nxt = 1'b1;
          end else begin
            sum_nxt = acc[63:0];
            if (vsat) ovf_nxt = 1'b1;
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          dist_nxt = v[31:0];
          dsat_nxt = vsat || ovf_r;
          sum_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    last_r <= last_nxt;
    x_r <= x_nxt;
    p_r <= p_nxt;
    step_r <= step_nxt;
    lm_r <= lm_nxt;
    e_r <= e_nxt;
    n_r <= n_nxt;
    mant_r <= mant_nxt;
    dist_r <= dist_nxt;
    dsat_r <= dsat_nxt;
  end

endmodule

// ----- sv/minkowski_distance.sv -----
// Minkowski distance of two vectors streamed one element pair per transfer.
// Input: push/full with in_elem_a, in_elem_b (signed Q16.16) and in_last_pair.
// Results: empty/pop with out_distance (unsigned Q16.16) and out_saturated;
// one result appears after each pair marked last.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects
// exponent_k (0, Q4.12) or exponent_recip (1, Q1.16); other indexes are ignored.
// A four-entry queue takes pairs while the power unit works. For a pair with
// a nonzero difference the unit takes the pair, runs the leading-one search,
// then the table, multiply and scale steps; a pair of equal elements is only
// taken. A last pair then adds the root (skipped when the sum is zero) before
// the result shows. The sustained rate is therefore set by this sequential
// power unit.
// The result register holds one result; while the receiver does not pop,
// the unit stalls at its next result and the queue fills, raising full.
// Reset (rst_n low, synchronous) empties queue and result, clears the sum and
// overflow flag, and sets k = 2.0 and 1/k = 0.5.
module minkowski_distance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic signed [31:0]                in_elem_a,
  input  logic signed [31:0]                in_elem_b,
  input  logic                              in_last_pair,
  output logic                              empty,
  input  logic                              pop,
  output logic [31:0]                       out_distance,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [md_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [16:0]                       cfg_data
);

  md_pkg::cfg_t  cfg_r;
  logic          q_valid, q_pop;
  md_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k <= 16'd8192;
      cfg_r.recip <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == md_pkg::REG_EXPONENT_K) cfg_r.k <= cfg_data[15:0];
      else if (cfg_index == md_pkg::REG_EXPONENT_RECIP) cfg_r.recip <= cfg_data;
    end
  end

  md_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last_pair(in_last_pair),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  md_power u_power (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .empty(empty), .pop(pop),
    .out_distance(out_distance), .out_saturated(out_saturated)
  );

endmodule

// ----- sv/md_checker.sv -----
module md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_last_pair,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_distance,
  input logic        out_saturated
);

  // Results owed: last pairs transferred in minus results transferred out.
  logic [7:0] owed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) owed_r <= '0;
    else owed_r <= owed_r + 8'(push && !full && in_last_pair) - 8'(pop && !empty);
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_distance) && $stable(out_saturated))
    else $error("waiting result changed or vanished");

  a_owed: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> owed_r != 8'd0)
    else $error("result shown with no last pair outstanding");

endmodule

bind minkowski_distance md_checker u_md_checker (
  .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_last_pair(in_last_pair),
  .empty(empty), .pop(pop), .out_distance(out_distance), .out_saturated(out_saturated)
);

// ----- sim/md_checker.sv -----
`timescale 1ns / 1ps

module md_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] in_elem_a,
  input  logic signed [31:0] in_elem_b,
  input  logic               in_last_pair,
  input  logic               empty,
  input  logic               pop,
  input  logic [31:0]        out_distance,
  input  logic               out_saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [md_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 distance_count
);

  localparam int NTAB = (1 << md_pkg::POW_TABLE_BITS) + 1;
  localparam int LR = 31 - md_pkg::POW_TABLE_BITS;
  localparam int ER = 16 - md_pkg::POW_TABLE_BITS;

  typedef struct {
    logic [31:0] distance;
    logic        saturated;
  } dist_t;

  longint unsigned log_q16 [NTAB];
  longint unsigned exp_q31 [NTAB];

  logic [15:0]     order_k;
  logic [16:0]     order_recip;
  longint unsigned sum_pow;
  bit              sum_ovf;
  dist_t           dist_fifo [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bw;
    res = 0;
    bw = 64'h4000_0000_0000_0000;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= res + bw) begin
        v = v - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  initial begin
    longint unsigned rt [md_pkg::POW_TABLE_BITS+1];
    longint unsigned m, v;
    longint unsigned f;
    rt[0] = 64'd1 << 32;
    for (int n = 1; n <= md_pkg::POW_TABLE_BITS; n++) rt[n] = int_sqrt(rt[n-1] << 31);
    for (int i = 0; i < (1 << md_pkg::POW_TABLE_BITS); i++) begin
      m = (64'd1 << 31) + (longint'(i) << LR);
      f = 0;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          f = f | (64'd1 << b);
          m = m >> 1;
        end
      end
      log_q16[i] = f;
      v = 64'd1 << 31;
      for (int n = 0; n < md_pkg::POW_TABLE_BITS; n++)
        if (((i >> n) & 1) != 0) v = (v * rt[md_pkg::POW_TABLE_BITS-n]) >> 31;
      exp_q31[i] = v;
    end
    log_q16[1 << md_pkg::POW_TABLE_BITS] = 65536;
    exp_q31[1 << md_pkg::POW_TABLE_BITS] = 64'd1 << 32;
  end

  // log2 of x (fb fraction bits) with 16 fraction bits.
  function automatic longint log2_q16(longint unsigned x, int fb);
    int p;
    int i;
    longint unsigned m, r;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    i = int'((m >> LR) & ((64'd1 << md_pkg::POW_TABLE_BITS) - 1));
    r = m & ((64'd1 << LR) - 1);
    m = log_q16[i] + (((log_q16[i+1] - log_q16[i]) * r) >> LR);
    return longint'(p - fb) * 65536 + longint'(m);
  endfunction

  function automatic longint unsigned pow2_scaled(longint x, int ob, longint unsigned cap,
                                                  output bit clamp);
    longint e, n, s;
    longint unsigned frac, i, r, mant, v;
    clamp = 1'b0;
    e = x + longint'(ob) * 65536;
    n = e >>> 16;
    frac = longint'(e - n * 65536);
    i = frac >> ER;
    r = frac & ((64'd1 << ER) - 1);
    mant = exp_q31[i] + (((exp_q31[i+1] - exp_q31[i]) * r) >> ER);
    if (n > 31) begin
      s = n - 31;
      if (s >= 64 || (mant >> (64 - s)) != 0) begin
        clamp = 1'b1;
        return cap;
      end
      v = mant << s;
    end else begin
      s = 31 - n;
      v = (s >= 64) ? 64'd0 : (mant >> s);
    end
    if (v > cap) begin
      clamp = 1'b1;
      return cap;
    end
    return v;
  endfunction

  task automatic add_pair(logic signed [31:0] a, logic signed [31:0] b, logic last);
    longint diff, e;
    longint unsigned term, root_val;
    bit clamp;
    dist_t res;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    if (diff != 0) begin
      e = (log2_q16(longint'(diff), 16) * longint'(order_k)) >>> 12;
      term = pow2_scaled(e, 32, 64'hFFFF_FFFF_FFFF_FFFF, clamp);
      if (term > 64'hFFFF_FFFF_FFFF_FFFF - sum_pow) begin
        sum_pow = 64'hFFFF_FFFF_FFFF_FFFF;
        clamp = 1'b1;
      end else begin
        sum_pow = sum_pow + term;
      end
      if (clamp) sum_ovf = 1'b1;
    end
    if (last) begin
      clamp = 1'b0;
      root_val = 0;
      if (sum_pow != 0) begin
        e = (log2_q16(sum_pow, 32) * longint'(order_recip)) >>> 16;
        root_val = pow2_scaled(e, 16, 64'hFFFF_FFFF, clamp);
      end
      res.distance = root_val[31:0];
      res.saturated = clamp | sum_ovf;
      dist_fifo.push_back(res);
      sum_pow = 0;
      sum_ovf = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    dist_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      order_k <= 16'd8192;
      order_recip <= 17'd32768;
      sum_pow = 0;
      sum_ovf = 1'b0;
      dist_fifo.delete();
      fail_count <= 0;
      distance_count <= 0;
    end else begin
      if (pop && !empty) begin
        distance_count <= distance_count + 1;
        if (dist_fifo.size() == 0) begin
          $error("distance transfer with nothing expected: %h", out_distance);
          errs++;
        end else begin
          want = dist_fifo.pop_front();
          if (out_distance !== want.distance) begin
            $error("distance: expected %h, got %h", want.distance, out_distance);
            errs++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, out_saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (push && !full) add_pair(in_elem_a, in_elem_b, in_last_pair);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == md_pkg::REG_EXPONENT_K) order_k <= cfg_data[15:0];
        else if (cfg_index == md_pkg::REG_EXPONENT_RECIP) order_recip <= cfg_data;
      end
    end
    pending <= dist_fifo.size();
  end
endmodule

// ----- sim/tb_minkowski_distance.sv -----
`timescale 1ns / 1ps

module tb_minkowski_distance;

  localparam logic [md_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] in_elem_a = '0;
  logic signed [31:0] in_elem_b = '0;
  logic               in_last_pair = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [31:0]        out_distance;
  logic               out_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [md_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  int fail_count, pending, distance_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int pair_count = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  minkowski_distance dut (.*);

  md_tb_checker chk (.*);

  always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_minkowski_distance failed");
      $finish;
    end
  end

  task automatic send_pair(logic signed [31:0] a, logic signed [31:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_elem_a <= a;
    in_elem_b <= b;
    in_last_pair <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    pair_count++;
  endtask

  task automatic write_reg(logic [md_pkg::CFG_IDX_BITS-1:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every distance has been seen and the power unit has settled.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_elem(logic [31:0] other, output logic [31:0] pick);
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom();
      1: v = other + $urandom_range(0, 1 << 17) - (1 << 16);
      2: v = other;
      3: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = other + $urandom_range(0, 255) - 128;
    endcase
    pick = v;
    return v;
  endfunction

  task automatic random_vectors(int npairs);
    int len;
    logic [31:0] a, b;
    while (npairs > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        a = $urandom();
        void'(rand_elem(a, b));
        send_pair(a, b, j == len - 1);
      end
      npairs -= len;
    end
  endtask

  initial begin
    logic [15:0] ks [6];
    logic [16:0] rs [6];
    ks = '{16'd8192, 16'd4096, 16'd65535, 16'd12288, 16'd0, 16'd6144};
    rs = '{17'd32768, 17'd65536, 17'd1, 17'd21845, 17'd0, 17'd43690};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors at reset settings: extremes, equal pairs, tiny differences.
    send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_pair(32'sd5, 32'sd5, 1'b0);
    send_pair(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_pair(32'sd1, 32'sd0, 1'b1);
    send_pair(32'sd0, 32'sd1, 1'b0);
    send_pair(32'sd1, 32'sd0, 1'b1);
    send_pair(32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_pair(32'sh0000_0000, 32'sh0002_0000, 1'b0);
    send_pair(32'shFFFF_0000, 32'sh0001_0000, 1'b1);
    for (int j = 0; j < 4; j++) send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, j == 3);
    send_pair(32'shFFFF_FFFF, 32'sh0000_0000, 1'b1);
    drain();
    write_reg(REG_UNUSED, 17'h1FFFF);
    write_reg(md_pkg::REG_EXPONENT_K, 17'd65535);
    write_reg(md_pkg::REG_EXPONENT_RECIP, 17'd1);
    send_pair(32'sd3, 32'sd0, 1'b1);
    send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      write_reg(md_pkg::REG_EXPONENT_K, {1'b0, ks[ph % 6]});
      write_reg(md_pkg::REG_EXPONENT_RECIP, rs[ph % 6]);
      random_vectors(95);
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    $display("sent %0d element pairs, checked %0d distances over six orders of k",
             pair_count, distance_count);
    $display("with free flow, sender gaps, receiver stalls and both together");
    if (fail_count == 0) begin
      $display("tb_minkowski_distance passed");
    end else begin
      $display("tb_minkowski_distance failed");
    end
    $finish;
  end
endmodule
